/* src/doubly_linked_list_engine_unit_macros.svh */
// Assertion macros for the linked-list engine.
`ifndef DOUBLY_LINKED_LIST_ENGINE_UNIT_MACROS_SVH
`define DOUBLY_LINKED_LIST_ENGINE_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define DLLE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dlle assertion failed");
// next-cycle implication
`define DLLE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dlle assertion failed");
`else
`define DLLE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DLLE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* src/dlle_pkg.sv */
package dlle_pkg;

    localparam int ACTION_W   = 4;
    localparam int NODE_ID_W  = 9;
    localparam int NEW_ID_W   = 8;
    localparam int LIST_ID_W  = 4;
    localparam int STATUS_W   = 2;
    localparam int LINK_OUT_W = 9;
    localparam int OWNER_W    = 4;

    localparam int NODE_SLOTS_DEF = 256;
    localparam int LIST_COUNT_DEF = 16;

    localparam logic [LINK_OUT_W-1:0] LINK_NULL_OUT = '1;

    localparam logic [ACTION_W-1:0] ACT_NODE_INIT  = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_LIST_INIT  = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_INS_AFTER  = 4'd2;
    localparam logic [ACTION_W-1:0] ACT_INS_BEFORE = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_INS_FIRST  = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_INS_LAST   = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_REMOVE     = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_NODE_QUERY = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_LIST_QUERY = 4'd8;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NEW_OWNED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_NODE  = 2'd2;

endpackage

/* src/doubly_linked_list_engine_unit.sv */
// Linked-list engine: circular doubly linked lists with one sentinel header per list,
// over NODE_SLOTS pool nodes and LIST_COUNT headers (header of list l is slot NODE_SLOTS+l).
// Input channel: i_in_valid / o_in_stall with action, node, new node and list number.
// Output channel: o_out_valid / i_out_stall, one result transaction per input transaction.
// All link, owner and flag state sits in one row-wide RAM (two read ports, one write port,
// registered reads).
// Result path: an accepted item is registered and its rows are read on entry to S_EVAL;
// once the result register is free, the result is loaded and o_out_valid rises.
// Init, query and rejected actions go back from S_EVAL to S_IDLE; an insert or remove
// passes S_W2 and, if needed, S_W3, since the single write port lets it rewrite up to
// three rows (the node, the anchor or its prev, the far neighbor), one per cycle.
// Reset: a clearing pass writes every row to unowned with null links, one row per cycle;
// o_in_stall is high meanwhile.
// Receiver stall: the result register holds its value. One more item may be accepted;
// it waits in evaluation, with the RAM untouched, until the result register frees up.
// Null links are reported as 511.
`include "doubly_linked_list_engine_unit_macros.svh"

module doubly_linked_list_engine_unit #(
    parameter int NODE_SLOTS = dlle_pkg::NODE_SLOTS_DEF,
    parameter int LIST_COUNT = dlle_pkg::LIST_COUNT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [dlle_pkg::ACTION_W-1:0]    i_action,
    input  logic [dlle_pkg::NODE_ID_W-1:0]   i_node_id,
    input  logic [dlle_pkg::NEW_ID_W-1:0]    i_new_node_id,
    input  logic [dlle_pkg::LIST_ID_W-1:0]   i_list_id,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [dlle_pkg::STATUS_W-1:0]    o_status,
    output logic [dlle_pkg::LINK_OUT_W-1:0]  o_next_link,
    output logic [dlle_pkg::LINK_OUT_W-1:0]  o_prev_link,
    output logic                             o_is_owned,
    output logic [dlle_pkg::OWNER_W-1:0]     o_owner_list,
    output logic                             o_is_terminal,
    output logic                             o_is_empty
);

    localparam int TOTAL  = NODE_SLOTS + LIST_COUNT;
    localparam int ADDR_W = $clog2(TOTAL);
    localparam int LINK_W = $clog2(TOTAL + 1);
    // wide enough for any port id, header id or stored link, plus a guard bit
    localparam int CMP_W  = ((LINK_W > dlle_pkg::NODE_ID_W) ? LINK_W : dlle_pkg::NODE_ID_W) + 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_W2    = 3'd3;
    localparam logic [2:0] S_W3    = 3'd4;

    typedef struct packed {
        logic                           owned;
        logic [dlle_pkg::OWNER_W-1:0]   owner;
        logic [LINK_W-1:0]              next;
        logic [LINK_W-1:0]              prev;
    } t_row;

    localparam t_row NULL_ROW = '{owned: 1'b0, owner: '0, next: '1, prev: '1};

    t_row                          r_mem [TOTAL];
    t_row                          r_rd0;
    t_row                          r_rd1;

    logic [2:0]                    r_state, n_state;
    logic [ADDR_W-1:0]             r_clr, n_clr;

    logic [dlle_pkg::ACTION_W-1:0] r_action;
    logic [CMP_W-1:0]              r_node;
    logic [CMP_W-1:0]              r_nn;
    logic [dlle_pkg::LIST_ID_W-1:0] r_lst;

    // follow-up write context
    logic [LINK_W-1:0]             r_la, n_la;
    logic [LINK_W-1:0]             r_lb, n_lb;
    logic [LINK_W-1:0]             r_lnn, n_lnn;
    logic                          r_rm, n_rm;
    logic                          r_before, n_before;
    logic                          r_self, n_self;
    logic                          r_a_en, n_a_en;
    logic                          r_b_en, n_b_en;

    logic                          r_ovalid;
    logic [dlle_pkg::STATUS_W-1:0] r_status, n_status;
    logic [dlle_pkg::LINK_OUT_W-1:0] r_onext, n_onext;
    logic [dlle_pkg::LINK_OUT_W-1:0] r_oprev, n_oprev;
    logic                          r_oowned, n_oowned;
    logic [dlle_pkg::OWNER_W-1:0]  r_oowner, n_oowner;
    logic                          r_oterm, n_oterm;
    logic                          r_oempty, n_oempty;

    logic                          accept;
    logic                          out_free;
    logic                          out_load;

    logic                          mem_we;
    logic [ADDR_W-1:0]             mem_waddr;
    t_row                          mem_wdata;
    logic                          mem_re0;
    logic [ADDR_W-1:0]             mem_ra0;
    logic                          mem_re1;
    logic [ADDR_W-1:0]             mem_ra1;

    logic [CMP_W-1:0]              in_node_w;
    logic [CMP_W-1:0]              in_nn_w;
    logic [CMP_W-1:0]              in_hdr_w;
    logic [CMP_W-1:0]              hdr_w;
    logic [CMP_W-1:0]              a_w;
    logic [CMP_W-1:0]              q_w;
    logic                          node_ok;
    logic                          list_ok;
    logic                          nn_bad;
    logic                          ins_before;
    logic [LINK_W-1:0]             nb;
    logic [LINK_W-1:0]             a_link;
    logic [LINK_W-1:0]             nn_link;
    logic [LINK_W-1:0]             node_link;
    logic                          nb_ok;
    logic                          p_ok;
    logic                          n_ok;
    t_row                          w2_row;
    t_row                          w3_row;

    function automatic logic is_slot(input logic [LINK_W-1:0] l);
        return CMP_W'(l) < CMP_W'(TOTAL);
    endfunction

    function automatic logic [dlle_pkg::LINK_OUT_W-1:0] link_port(input logic [LINK_W-1:0] l);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(l);
        return is_slot(l) ? ext[dlle_pkg::LINK_OUT_W-1:0] : dlle_pkg::LINK_NULL_OUT;
    endfunction

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_ovalid || !i_out_stall;
    assign out_load = (r_state == S_EVAL) && out_free;

    assign in_node_w = CMP_W'(i_node_id);
    assign in_nn_w   = CMP_W'(i_new_node_id);
    assign in_hdr_w  = CMP_W'(NODE_SLOTS) + CMP_W'(i_list_id);

    // item decode, valid during evaluation
    assign hdr_w      = CMP_W'(NODE_SLOTS) + CMP_W'(r_lst);
    assign node_ok    = r_node < CMP_W'(TOTAL);
    assign list_ok    = CMP_W'(r_lst) < CMP_W'(LIST_COUNT);
    assign nn_bad     = (r_nn >= CMP_W'(NODE_SLOTS)) || r_rd0.owned;
    assign ins_before = (r_action == dlle_pkg::ACT_INS_BEFORE)
                     || (r_action == dlle_pkg::ACT_INS_LAST);
    assign a_w        = ((r_action == dlle_pkg::ACT_INS_FIRST)
                     || (r_action == dlle_pkg::ACT_INS_LAST)) ? hdr_w : r_node;
    assign q_w        = (r_action == dlle_pkg::ACT_LIST_QUERY) ? hdr_w : r_node;
    assign a_link     = a_w[LINK_W-1:0];
    assign nn_link    = r_nn[LINK_W-1:0];
    assign node_link  = r_node[LINK_W-1:0];
    assign nb         = ins_before ? r_rd1.prev : r_rd1.next;
    assign nb_ok      = is_slot(nb);
    assign p_ok       = is_slot(r_rd1.prev);
    assign n_ok       = is_slot(r_rd1.next);

    // anchor row (or prev neighbor on remove)
    always_comb begin
        if (r_rm) begin
            w2_row      = r_rd0;
            w2_row.next = r_lb;
            if (r_self) begin
                w2_row.prev = r_la;
            end
        end else begin
            w2_row = r_rd1;
            if (r_before) begin
                w2_row.prev = r_lnn;
                if (r_self) begin
                    w2_row.next = r_lnn;
                end
            end else begin
                w2_row.next = r_lnn;
                if (r_self) begin
                    w2_row.prev = r_lnn;
                end
            end
        end
    end

    // far neighbor row
    always_comb begin
        if (r_rm) begin
            w3_row      = r_rd1;
            w3_row.prev = r_la;
        end else begin
            w3_row = r_rd0;
            if (r_before) begin
                w3_row.next = r_lnn;
            end else begin
                w3_row.prev = r_lnn;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        mem_we    = 1'b0;
        mem_waddr = r_clr;
        mem_wdata = NULL_ROW;
        mem_re0   = 1'b0;
        mem_ra0   = in_nn_w[ADDR_W-1:0];
        mem_re1   = 1'b0;
        mem_ra1   = in_node_w[ADDR_W-1:0];
        n_la      = r_la;
        n_lb      = r_lb;
        n_lnn     = r_lnn;
        n_rm      = r_rm;
        n_before  = r_before;
        n_self    = r_self;
        n_a_en    = r_a_en;
        n_b_en    = r_b_en;
        n_status  = dlle_pkg::ST_OK;
        n_onext   = dlle_pkg::LINK_NULL_OUT;
        n_oprev   = dlle_pkg::LINK_NULL_OUT;
        n_oowned  = 1'b0;
        n_oowner  = '0;
        n_oterm   = 1'b0;
        n_oempty  = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                n_clr  = r_clr + 1'b1;
                if (r_clr == ADDR_W'(TOTAL - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    mem_re0 = 1'b1;
                    mem_re1 = 1'b1;
                    if ((i_action == dlle_pkg::ACT_INS_FIRST)
                            || (i_action == dlle_pkg::ACT_INS_LAST)
                            || (i_action == dlle_pkg::ACT_LIST_QUERY)) begin
                        mem_ra1 = in_hdr_w[ADDR_W-1:0];
                    end
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (out_free) begin
                    n_state = S_IDLE;
                    n_rm    = 1'b0;
                    unique case (r_action) inside
                        dlle_pkg::ACT_NODE_INIT: begin
                            if (node_ok) begin
                                mem_we    = 1'b1;
                                mem_waddr = r_node[ADDR_W-1:0];
                                mem_wdata = NULL_ROW;
                            end else begin
                                n_status = dlle_pkg::ST_BAD_NODE;
                            end
                        end
                        dlle_pkg::ACT_LIST_INIT: begin
                            if (list_ok) begin
                                mem_we    = 1'b1;
                                mem_waddr = hdr_w[ADDR_W-1:0];
                                mem_wdata = '{owned: 1'b1, owner: r_lst,
                                              next: hdr_w[LINK_W-1:0],
                                              prev: hdr_w[LINK_W-1:0]};
                            end else begin
                                n_status = dlle_pkg::ST_BAD_NODE;
                            end
                        end
                        dlle_pkg::ACT_INS_AFTER, dlle_pkg::ACT_INS_BEFORE,
                        dlle_pkg::ACT_INS_FIRST, dlle_pkg::ACT_INS_LAST: begin
                            if (nn_bad) begin
                                n_status = dlle_pkg::ST_NEW_OWNED;
                            end else if (!(a_w < CMP_W'(TOTAL)) || !r_rd1.owned) begin
                                n_status = dlle_pkg::ST_BAD_NODE;
                            end else begin
                                // new node row now, anchor and neighbor rows follow
                                mem_we    = 1'b1;
                                mem_waddr = r_nn[ADDR_W-1:0];
                                mem_wdata = '{owned: 1'b1, owner: r_rd1.owner,
                                              next: ins_before ? a_link : nb,
                                              prev: ins_before ? nb : a_link};
                                mem_re0   = nb_ok;
                                mem_ra0   = nb[ADDR_W-1:0];
                                n_la      = a_link;
                                n_lb      = nb;
                                n_lnn     = nn_link;
                                n_before  = ins_before;
                                n_self    = (nb == a_link);
                                n_a_en    = 1'b1;
                                n_b_en    = nb_ok && (nb != a_link) && (nb != nn_link);
                                n_state   = S_W2;
                            end
                        end
                        dlle_pkg::ACT_REMOVE: begin
                            if (!node_ok || !r_rd1.owned || (r_node >= CMP_W'(NODE_SLOTS))) begin
                                n_status = dlle_pkg::ST_BAD_NODE;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_node[ADDR_W-1:0];
                                mem_wdata = NULL_ROW;
                                mem_re0   = p_ok;
                                mem_ra0   = r_rd1.prev[ADDR_W-1:0];
                                mem_re1   = n_ok;
                                mem_ra1   = r_rd1.next[ADDR_W-1:0];
                                n_rm      = 1'b1;
                                n_la      = r_rd1.prev;
                                n_lb      = r_rd1.next;
                                n_self    = (r_rd1.next == r_rd1.prev);
                                n_a_en    = p_ok && (r_rd1.prev != node_link);
                                n_b_en    = n_ok && (r_rd1.next != node_link)
                                         && (r_rd1.next != r_rd1.prev);
                                n_state   = S_W2;
                            end
                        end
                        dlle_pkg::ACT_NODE_QUERY, dlle_pkg::ACT_LIST_QUERY: begin
                            if ((r_action == dlle_pkg::ACT_NODE_QUERY) ? !node_ok : !list_ok) begin
                                n_status = dlle_pkg::ST_BAD_NODE;
                            end else begin
                                n_onext  = link_port(r_rd1.next);
                                n_oprev  = link_port(r_rd1.prev);
                                n_oowned = r_rd1.owned;
                                if (r_rd1.owned) begin
                                    n_oowner = r_rd1.owner;
                                    n_oterm  = (q_w == CMP_W'(NODE_SLOTS) + CMP_W'(r_rd1.owner));
                                end
                                if (r_action == dlle_pkg::ACT_LIST_QUERY) begin
                                    n_oempty = (CMP_W'(r_rd1.next) == q_w);
                                end
                            end
                        end
                        default: begin
                            n_status = dlle_pkg::ST_BAD_NODE;
                        end
                    endcase
                end
            end
            S_W2: begin
                mem_we    = r_a_en;
                mem_waddr = r_la[ADDR_W-1:0];
                mem_wdata = w2_row;
                n_state   = r_b_en ? S_W3 : S_IDLE;
            end
            S_W3: begin
                mem_we    = 1'b1;
                mem_waddr = r_lb[ADDR_W-1:0];
                mem_wdata = w3_row;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re0) begin
            r_rd0 <= r_mem[mem_ra0];
        end
        if (mem_re1) begin
            r_rd1 <= r_mem[mem_ra1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_action;
            r_node   <= in_node_w;
            r_nn     <= in_nn_w;
            r_lst    <= i_list_id;
        end
        r_la     <= n_la;
        r_lb     <= n_lb;
        r_lnn    <= n_lnn;
        r_rm     <= n_rm;
        r_before <= n_before;
        r_self   <= n_self;
        r_a_en   <= n_a_en;
        r_b_en   <= n_b_en;
        if (out_load) begin
            r_status <= n_status;
            r_onext  <= n_onext;
            r_oprev  <= n_oprev;
            r_oowned <= n_oowned;
            r_oowner <= n_oowner;
            r_oterm  <= n_oterm;
            r_oempty <= n_oempty;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_ovalid;
    assign o_status      = r_status;
    assign o_next_link   = r_onext;
    assign o_prev_link   = r_oprev;
    assign o_is_owned    = r_oowned;
    assign o_owner_list  = r_oowner;
    assign o_is_terminal = r_oterm;
    assign o_is_empty    = r_oempty;

    `DLLE_ASSERT_IMP(a_waddr_in_range, i_clk, i_rst_n, mem_we, (32'(mem_waddr) < TOTAL))
    `DLLE_ASSERT_NXT(a_accept_to_eval, i_clk, i_rst_n, accept, (r_state == S_EVAL))
    `DLLE_ASSERT_NXT(a_eval_gives_result, i_clk, i_rst_n, out_load, o_out_valid)
    `DLLE_ASSERT_IMP(a_w3_after_w2, i_clk, i_rst_n, (r_state == S_W3), ($past(r_state) == S_W2))
    `DLLE_ASSERT_IMP(a_no_result_in_clear, i_clk, i_rst_n, (r_state == S_CLEAR), !o_out_valid)

endmodule
